### sv/ftwf_pkg.sv
// ----------------------------------------------------------------------------
// ftwf_pkg: shared types and constants of the five-tuple whitelist filter
// Request and response payloads, the stored rule layout and protocol codes.
// ----------------------------------------------------------------------------
package ftwf_pkg;

    localparam int RULE_COUNT_DEF = 8;

    localparam logic ACT_CLASSIFY = 1'b0;
    localparam logic ACT_WRITE    = 1'b1;

    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] PORT_WILDCARD = 16'd0;

    typedef struct packed {
        logic        action;
        logic [2:0]  rule_slot;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
        logic        rule_enable;
    } t_in_req;

    typedef struct packed {
        logic       accept;
        logic [2:0] matched_rule;
    } t_out_rsp;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  proto;
    } t_rule;

endpackage

### sv/ftwf_rule_store.sv
// ----------------------------------------------------------------------------
// ftwf_rule_store: rule table memory with per-slot enable bits
// One write port and one registered read port; enable bits clear at reset.
// ----------------------------------------------------------------------------
module ftwf_rule_store #(
    parameter int RULE_COUNT = ftwf_pkg::RULE_COUNT_DEF,
    parameter int IDX_W      = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_we,
    input  logic [IDX_W-1:0]    i_waddr,
    input  ftwf_pkg::t_rule     i_wrule,
    input  logic                i_wact,
    input  logic                i_re,
    input  logic [IDX_W-1:0]    i_raddr,
    output ftwf_pkg::t_rule     o_rd_rule,
    output logic                o_rd_act
);
    import ftwf_pkg::*;

    t_rule                  r_mem [RULE_COUNT];
    logic [RULE_COUNT-1:0]  r_active;
    t_rule                  r_rd_rule;
    logic                   r_rd_act;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wrule;
        end
        if (i_re) begin
            r_rd_rule <= r_mem[i_raddr];
            r_rd_act  <= r_active[i_raddr];
        end
    end

    // Enable bits stand in for the cleared table: an inactive slot never hits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_we) begin
            r_active[i_waddr] <= i_wact;
        end
    end

    assign o_rd_rule = r_rd_rule;
    assign o_rd_act  = r_rd_act;

endmodule

### sv/ftwf_match.sv
// ----------------------------------------------------------------------------
// ftwf_match: compare one stored rule against the packet header
// Address and protocol must agree; ports count only for TCP and UDP.
// ----------------------------------------------------------------------------
module ftwf_match (
    input  ftwf_pkg::t_rule   i_rule,
    input  logic              i_act,
    input  ftwf_pkg::t_in_req i_pkt,
    output logic              o_hit
);
    import ftwf_pkg::*;

    logic base_ok;
    logic has_ports;
    logic sp_ok;
    logic dp_ok;

    assign base_ok   = (i_rule.src_addr == i_pkt.src_addr)
                    && (i_rule.dst_addr == i_pkt.dst_addr)
                    && (i_rule.proto    == i_pkt.protocol);
    assign has_ports = (i_pkt.protocol == PROTO_TCP) || (i_pkt.protocol == PROTO_UDP);
    // Zero rule port is a wildcard
    assign sp_ok     = (i_rule.src_port == PORT_WILDCARD) || (i_rule.src_port == i_pkt.src_port);
    assign dp_ok     = (i_rule.dst_port == PORT_WILDCARD) || (i_rule.dst_port == i_pkt.dst_port);

    assign o_hit = i_act && base_ok && (!has_ports || (sp_ok && dp_ok));

endmodule

### sv/five_tuple_whitelist_filter_core.sv
// ----------------------------------------------------------------------------
// five_tuple_whitelist_filter_core: IPv4 five-tuple whitelist, first match
// Default-drop filter that scans a rule table one slot per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_req) carries two kinds of
//   request. A write-rule request (action = 1) stores addresses, ports,
//   protocol and enable into the slot given by rule_slot and gives no
//   response. A slot number not below RULE_COUNT is ignored.
//   A classify request (action = 0) scans the slots in ascending order
//   through a single comparator and returns one response (o_out_valid /
//   i_out_ready / o_out_rsp): accept and the first matching slot, or accept 0
//   and slot 0 when no enabled rule matches.
//   Scan: a classify request reads one slot per cycle from the rule memory
//   (registered read) and stops at the first hit or after the last slot;
//   the rule memory read port and the single comparator set the pace.
//   o_in_ready is high only while the sequencer is idle, so the next request
//   is taken only after the response has loaded into the output register.
//   Reset clears every enable bit, so all packets drop until rules load.
//   A stalled receiver holds the response in the output register; the next
//   request is still taken and scanned, and its result waits until the
//   output register is free.
// ----------------------------------------------------------------------------
module five_tuple_whitelist_filter_core #(
    parameter int RULE_COUNT = ftwf_pkg::RULE_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ftwf_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ftwf_pkg::t_out_rsp o_out_rsp
);
    import ftwf_pkg::*;

    localparam int IDX_W = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RULE_COUNT - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // Sequencer state and scan pointers
    logic [1:0]       r_state,     n_state;
    t_in_req          r_pkt,       n_pkt;
    logic [IDX_W-1:0] r_issue_idx, n_issue_idx;
    logic             r_issuing,   n_issuing;
    logic             r_cmp_vld,   n_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx,   n_cmp_idx;
    t_out_rsp         r_res,       n_res;
    logic             r_out_vld,   n_out_vld;
    t_out_rsp         r_out_rsp,   n_out_rsp;

    logic             in_fire;
    logic [6:0]       slot_ext;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_rule            wr_rule;
    logic             rd_en;
    t_rule            rd_rule;
    logic             rd_act;
    logic             hit;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    // Rule writes: drop slots beyond the table
    assign slot_ext = 7'(i_in_req.rule_slot);
    assign wr_en    = in_fire && (i_in_req.action == ACT_WRITE) && (slot_ext < 7'(RULE_COUNT));
    assign wr_addr  = slot_ext[IDX_W-1:0];

    always_comb begin
        wr_rule.src_addr = i_in_req.src_addr;
        wr_rule.dst_addr = i_in_req.dst_addr;
        wr_rule.src_port = i_in_req.src_port;
        wr_rule.dst_port = i_in_req.dst_port;
        wr_rule.proto    = i_in_req.protocol;
    end

    assign rd_en = (r_state == ST_SCAN) && r_issuing;

    ftwf_rule_store #(
        .RULE_COUNT (RULE_COUNT),
        .IDX_W      (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (wr_en),
        .i_waddr   (wr_addr),
        .i_wrule   (wr_rule),
        .i_wact    (i_in_req.rule_enable),
        .i_re      (rd_en),
        .i_raddr   (r_issue_idx),
        .o_rd_rule (rd_rule),
        .o_rd_act  (rd_act)
    );

    ftwf_match u_match (
        .i_rule (rd_rule),
        .i_act  (rd_act),
        .i_pkt  (r_pkt),
        .o_hit  (hit)
    );

    always_comb begin
        n_state     = r_state;
        n_pkt       = r_pkt;
        n_issue_idx = r_issue_idx;
        n_issuing   = r_issuing;
        n_cmp_vld   = rd_en;
        n_cmp_idx   = r_issue_idx;
        n_res       = r_res;
        n_out_vld   = r_out_vld;
        n_out_rsp   = r_out_rsp;

        // Release the response once the receiver takes it
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && (i_in_req.action == ACT_CLASSIFY)) begin
                    n_pkt       = i_in_req;
                    n_issue_idx = '0;
                    n_issuing   = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Advance the read pointer one slot per cycle
                if (rd_en) begin
                    if (r_issue_idx == LAST_IDX) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_issue_idx = IDX_W'(r_issue_idx + 1'b1);
                    end
                end
                // Compare the slot read in the previous cycle; first hit wins
                if (r_cmp_vld) begin
                    if (hit) begin
                        n_res.accept       = 1'b1;
                        n_res.matched_rule = 3'(r_cmp_idx);
                        n_issuing          = 1'b0;
                        n_cmp_vld          = 1'b0;
                        n_state            = ST_FIN;
                    end else if (r_cmp_idx == LAST_IDX) begin
                        n_res.accept       = 1'b0;
                        n_res.matched_rule = 3'd0;
                        n_issuing          = 1'b0;
                        n_cmp_vld          = 1'b0;
                        n_state            = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                // Hold the result until the output register is free
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld = 1'b1;
                    n_out_rsp = r_res;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state   = ST_IDLE;
                n_issuing = 1'b0;
                n_cmp_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_issuing <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issuing <= n_issuing;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pkt       <= n_pkt;
        r_issue_idx <= n_issue_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_res       <= n_res;
        r_out_rsp   <= n_out_rsp;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_rsp   = r_out_rsp;

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the five-tuple whitelist filter core
// Drives rule writes and packet classify requests over the input channel,
// predicts each verdict from a local copy of the rule table, and checks
// every response in order; both sides stall in random bursts but for the last stretch.
// ----------------------------------------------------------------------------
module tb;
    import ftwf_pkg::*;

    localparam int         NUM_SLOTS   = RULE_COUNT_DEF;
    localparam int         SCAN_CYCLES = NUM_SLOTS + 3;
    localparam int         MAX_REPORTS = 10;
    localparam logic [7:0] PROTO_ICMP  = 8'd1;

    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    t_in_req  in_req    = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_out_rsp out_rsp;

    // Local rule table, updated as each request is accepted
    t_rule       rule_tbl [NUM_SLOTS];
    logic        rule_on  [NUM_SLOTS];
    t_out_rsp    verdict_q [$];
    int          mismatch_cnt = 0;
    logic        bursts_on    = 1'b1;

    // Small value pools so random packets hit stored rules often
    logic [31:0] src_pool  [4];
    logic [31:0] dst_pool  [4];
    logic [15:0] port_pool [4];

    five_tuple_whitelist_filter_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (out_rsp)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Verdict prediction
    // ------------------------------------------------------------------------
    function automatic t_out_rsp classify_pkt(input t_in_req pkt);
        t_out_rsp verdict;
        logic     ported;
        logic     hit;
        verdict = '0;
        ported  = (pkt.protocol == PROTO_TCP) || (pkt.protocol == PROTO_UDP);
        // Scan downward so the lowest matching slot is the one left standing
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
            hit = rule_on[s]
                && rule_tbl[s].src_addr == pkt.src_addr
                && rule_tbl[s].dst_addr == pkt.dst_addr
                && rule_tbl[s].proto    == pkt.protocol
                && (!ported
                    || ((rule_tbl[s].src_port == PORT_WILDCARD
                         || rule_tbl[s].src_port == pkt.src_port)
                        && (rule_tbl[s].dst_port == PORT_WILDCARD
                            || rule_tbl[s].dst_port == pkt.dst_port)));
            if (hit) begin
                verdict.accept       = 1'b1;
                verdict.matched_rule = 3'(s);
            end
        end
        return verdict;
    endfunction

    // Apply one accepted request: store a rule or queue the expected verdict
    function automatic void apply_req(input t_in_req req);
        t_rule r;
        if (req.action == ACT_WRITE) begin
            if (int'(req.rule_slot) < NUM_SLOTS) begin
                r.src_addr = req.src_addr;
                r.dst_addr = req.dst_addr;
                r.src_port = req.src_port;
                r.dst_port = req.dst_port;
                r.proto    = req.protocol;
                rule_tbl[req.rule_slot] = r;
                rule_on[req.rule_slot]  = req.rule_enable;
            end
        end else begin
            verdict_q.push_back(classify_pkt(req));
        end
    endfunction

    // ------------------------------------------------------------------------
    // Request driver and response side
    // ------------------------------------------------------------------------
    // Offer one request and hold it until taken. Valid is left high on
    // return, so the caller either sends again at once or calls drain.
    task automatic send_req(input t_in_req req);
        int gap;
        gap = 0;
        if (bursts_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge i_clk); while (!in_ready);
        apply_req(req);
    endtask

    // Drop valid and wait for every pending verdict to come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (verdict_q.size() != 0);
    endtask

    // Receiver: stall in random bursts while bursts are enabled
    initial begin
        int stall;
        forever begin
            @(posedge i_clk);
            if (bursts_on && i_rst_n && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 19);
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Check each response against the oldest expected verdict
    always @(posedge i_clk) begin
        t_out_rsp want;
        if (i_rst_n && out_valid && out_ready) begin
            if (verdict_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected response: accept=%0d rule=%0d",
                             out_rsp.accept, out_rsp.matched_rule);
            end else begin
                want = verdict_q.pop_front();
                if (out_rsp.accept !== want.accept
                    || out_rsp.matched_rule !== want.matched_rule) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display({"verdict mismatch: expected accept=%0d rule=%0d,",
                                  " got accept=%0d rule=%0d"},
                                 want.accept, want.matched_rule,
                                 out_rsp.accept, out_rsp.matched_rule);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------------
    function automatic t_in_req build_req(input logic act, input logic [2:0] slot,
                                          input logic [31:0] sa, input logic [31:0] da,
                                          input logic [15:0] sp, input logic [15:0] dp,
                                          input logic [7:0] proto, input logic en);
        t_in_req r;
        r.action      = act;
        r.rule_slot   = slot;
        r.src_addr    = sa;
        r.dst_addr    = da;
        r.src_port    = sp;
        r.dst_port    = dp;
        r.protocol    = proto;
        r.rule_enable = en;
        return r;
    endfunction

    function automatic logic [7:0] pick_proto();
        case ($urandom_range(0, 6))
            0, 1:    return PROTO_TCP;
            2, 3:    return PROTO_UDP;
            4:       return PROTO_ICMP;
            5:       return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_port();
        return ($urandom_range(0, 2) == 0) ? PORT_WILDCARD : port_pool[$urandom_range(0, 3)];
    endfunction

    function automatic t_in_req make_rule();
        t_in_req r;
        r = build_req(ACT_WRITE, 3'($urandom), src_pool[$urandom_range(0, 3)],
                      dst_pool[$urandom_range(0, 3)], pick_port(), pick_port(),
                      pick_proto(), $urandom_range(0, 5) != 0);
        // Occasionally write a rule of pure noise
        if ($urandom_range(0, 7) == 0) begin
            r.src_addr = $urandom;
            r.dst_addr = $urandom;
            r.src_port = 16'($urandom);
            r.dst_port = 16'($urandom);
            r.protocol = 8'($urandom);
        end
        return r;
    endfunction

    function automatic t_in_req make_pkt();
        t_in_req p;
        t_rule   r;
        int      s;
        int      bit_no;
        p = build_req(ACT_CLASSIFY, 3'($urandom), src_pool[$urandom_range(0, 3)],
                      dst_pool[$urandom_range(0, 3)], port_pool[$urandom_range(0, 3)],
                      port_pool[$urandom_range(0, 3)], pick_proto(), 1'($urandom));
        case ($urandom_range(0, 9))
            0: begin
                p.src_addr = $urandom;
                p.dst_addr = $urandom;
                p.src_port = 16'($urandom);
                p.dst_port = 16'($urandom);
                p.protocol = 8'($urandom);
            end
            1, 2: ;
            default: begin
                // Aim at a stored rule; fill wildcard ports with anything
                s = $urandom_range(0, NUM_SLOTS - 1);
                r = rule_tbl[s];
                p.src_addr = r.src_addr;
                p.dst_addr = r.dst_addr;
                p.protocol = r.proto;
                p.src_port = (r.src_port == PORT_WILDCARD) ? 16'($urandom) : r.src_port;
                p.dst_port = (r.dst_port == PORT_WILDCARD) ? 16'($urandom) : r.dst_port;
                // Flip one bit of one field now and then to just miss
                if ($urandom_range(0, 3) == 0) begin
                    bit_no = $urandom_range(0, 31);
                    case ($urandom_range(0, 4))
                        0: p.src_addr[bit_no]      = ~p.src_addr[bit_no];
                        1: p.dst_addr[bit_no]      = ~p.dst_addr[bit_no];
                        2: p.src_port[bit_no % 16] = ~p.src_port[bit_no % 16];
                        3: p.dst_port[bit_no % 16] = ~p.dst_port[bit_no % 16];
                        default: p.protocol[bit_no % 8] = ~p.protocol[bit_no % 8];
                    endcase
                end
            end
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Table is empty after reset: everything drops, zero packet included
    task automatic test_empty_table();
        send_req(build_req(ACT_CLASSIFY, 3'd0, 32'h0, 32'h0, 16'h0, 16'h0, 8'h00, 1'b0));
        send_req(build_req(ACT_CLASSIFY, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           16'hFFFF, 16'hFFFF, 8'hFF, 1'b1));
        send_req(build_req(ACT_CLASSIFY, 3'd0, 32'h0, 32'h0, 16'h0, 16'h0, PROTO_TCP, 1'b0));
        drain();
    endtask

    // Exact ports, wildcard ports, non-port protocols, field misses
    task automatic test_port_rules();
        logic [31:0] a;
        logic [31:0] b;
        a = 32'h0A00_0001;
        b = 32'hAC10_0A05;
        send_req(build_req(ACT_WRITE, 3'd0, a, b, 16'd1234, 16'd80, PROTO_TCP, 1'b1));
        send_req(build_req(ACT_CLASSIFY, 3'd5, a, b, 16'd1234, 16'd80, PROTO_TCP, 1'b1));
        send_req(build_req(ACT_CLASSIFY, 3'd0, a, b, 16'd1235, 16'd80, PROTO_TCP, 1'b0));
        send_req(build_req(ACT_CLASSIFY, 3'd0, a, b, 16'd1234, 16'd80, PROTO_UDP, 1'b0));
        send_req(build_req(ACT_CLASSIFY, 3'd0, a, b ^ 32'h1, 16'd1234, 16'd80,
                           PROTO_TCP, 1'b0));
        send_req(build_req(ACT_WRITE, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           PORT_WILDCARD, PORT_WILDCARD, PROTO_UDP, 1'b1));
        send_req(build_req(ACT_CLASSIFY, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           16'hFFFF, 16'hFFFF, PROTO_UDP, 1'b0));
        send_req(build_req(ACT_CLASSIFY, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           16'h0, 16'h0, PROTO_UDP, 1'b0));
        send_req(build_req(ACT_WRITE, 3'd3, a, b, 16'h1234, 16'hFFFF, PROTO_ICMP, 1'b1));
        send_req(build_req(ACT_CLASSIFY, 3'd0, a, b, 16'd1, 16'd2, PROTO_ICMP, 1'b0));
        send_req(build_req(ACT_WRITE, 3'd4, 32'h0, 32'h0, 16'h0, 16'h0, 8'h00, 1'b1));
        send_req(build_req(ACT_CLASSIFY, 3'd0, 32'h0, 32'h0, 16'h0, 16'h0, 8'h00, 1'b0));
        send_req(build_req(ACT_WRITE, 3'd6, a, b, PORT_WILDCARD, 16'd443, PROTO_TCP, 1'b1));
        send_req(build_req(ACT_CLASSIFY, 3'd0, a, b, 16'd999, 16'd443, PROTO_TCP, 1'b0));
        send_req(build_req(ACT_CLASSIFY, 3'd0, a, b, 16'd999, 16'd444, PROTO_TCP, 1'b0));
        drain();
    endtask

    // Lowest enabled slot wins; a disabled slot hands over to the next one
    task automatic test_first_match();
        logic [31:0] a;
        logic [31:0] b;
        a = 32'h0A00_0001;
        b = 32'hAC10_0A05;
        send_req(build_req(ACT_WRITE, 3'd5, a, b, PORT_WILDCARD, PORT_WILDCARD,
                           PROTO_TCP, 1'b1));
        send_req(build_req(ACT_CLASSIFY, 3'd0, a, b, 16'd1234, 16'd80, PROTO_TCP, 1'b0));
        send_req(build_req(ACT_WRITE, 3'd0, a, b, 16'd1234, 16'd80, PROTO_TCP, 1'b0));
        send_req(build_req(ACT_CLASSIFY, 3'd0, a, b, 16'd1234, 16'd80, PROTO_TCP, 1'b0));
        send_req(build_req(ACT_WRITE, 3'd2, a, b, 16'd1234, PORT_WILDCARD, PROTO_TCP, 1'b1));
        send_req(build_req(ACT_CLASSIFY, 3'd0, a, b, 16'd1234, 16'd80, PROTO_TCP, 1'b0));
        drain();
    endtask

    // Mixed rule writes and classify requests aimed at the stored rules
    task automatic run_traffic(input int n_items);
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 3) == 0) send_req(make_rule());
            else                          send_req(make_pkt());
        end
        drain();
    endtask

    task automatic test_random_traffic();
        src_pool[0] = 32'h0;
        src_pool[1] = 32'hFFFF_FFFF;
        dst_pool[0] = 32'hFFFF_FFFF;
        dst_pool[1] = 32'h0;
        for (int k = 2; k < 4; k++) begin
            src_pool[k] = $urandom;
            dst_pool[k] = $urandom;
        end
        port_pool[0] = 16'hFFFF;
        for (int k = 1; k < 4; k++) port_pool[k] = 16'($urandom);
        run_traffic(1000);
    endtask

    // Last stretch at full rate: no gaps and no stalls
    task automatic test_full_rate();
        bursts_on = 1'b0;
        run_traffic(300);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            rule_tbl[s] = '0;
            rule_on[s]  = 1'b0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_port_rules();
        test_first_match();
        test_random_traffic();
        test_full_rate();

        // Give a late or stray response time to show up
        repeat (4 * SCAN_CYCLES) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            $display("%0d expected responses never arrived", verdict_q.size());
            mismatch_cnt += verdict_q.size();
        end
        if (mismatch_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
